// ----- rtl/zdse_pkg.sv -----
package zdse_pkg;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_CRC32_MODE     = 1'b0;
    localparam reg_idx_t REG_ESCAPE_CONTROL = 1'b1;

    localparam logic [7:0]  ZDLE_CODE      = 8'h18;
    localparam logic [7:0]  XON_CODE       = 8'h11;
    localparam logic [7:0]  XOFF_CODE      = 8'h13;
    localparam logic [7:0]  DLE_CODE       = 8'h10;
    localparam logic [7:0]  CR_CODE        = 8'h0d;
    localparam logic [7:0]  HIGH_BIT       = 8'h80;
    localparam logic [7:0]  ESC_FLIP       = 8'h40;
    localparam logic [7:0]  CTRL_MASK      = 8'h60;
    localparam logic [7:0]  DEL_CODE       = 8'h7f;
    localparam logic [7:0]  DEL_HI_CODE    = 8'hff;
    localparam logic [7:0]  RUB0_CODE      = 8'h6c;
    localparam logic [7:0]  RUB1_CODE      = 8'h6d;
    localparam logic [7:0]  FRAME_END_BASE = 8'h68;
    localparam logic [1:0]  FE_ACK         = 2'd3;
    localparam logic [15:0] POLY16         = 16'h1021;
    localparam logic [31:0] POLY32         = 32'hedb88320;
    localparam logic [31:0] CRC32_INIT     = 32'hffffffff;
    localparam logic [31:0] CRC16_INIT     = 32'h00000000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
        logic [1:0] frame_end_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic crc32_mode;
        logic escape_control;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic fire;
    } seq_stat_t;

    function automatic logic [31:0] crc_init(input logic mode32);
        return mode32 ? CRC32_INIT : CRC16_INIT;
    endfunction

    // One byte through the bitwise CRC, either flavor.
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b,
                                             input logic mode32);
        logic [31:0] c32;
        logic [15:0] c16;
        c32 = crc ^ {24'h000000, b};
        c16 = crc[15:0] ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c32 = c32[0] ? ((c32 >> 1) ^ POLY32) : (c32 >> 1);
            c16 = c16[15] ? ((c16 << 1) ^ POLY16) : (c16 << 1);
        end
        return mode32 ? c32 : {16'h0000, c16};
    endfunction

    function automatic logic esc_needed(input logic [7:0] v, input logic ctl);
        logic always_esc;
        always_esc = (v == ZDLE_CODE) || (v == DLE_CODE) || (v == (DLE_CODE | HIGH_BIT)) ||
                     (v == XON_CODE) || (v == XOFF_CODE) ||
                     (v == (XON_CODE | HIGH_BIT)) || (v == (XOFF_CODE | HIGH_BIT)) ||
                     (v == CR_CODE) || (v == (CR_CODE | HIGH_BIT));
        return always_esc ||
               (ctl && ((v == DEL_CODE) || (v == DEL_HI_CODE) || ((v & CTRL_MASK) == 8'h00)));
    endfunction

    // Byte that follows ZDLE for an escaped value.
    function automatic logic [7:0] esc_second(input logic [7:0] v, input logic ctl);
        if (ctl && (v == DEL_CODE)) begin
            return RUB0_CODE;
        end else if (ctl && (v == DEL_HI_CODE)) begin
            return RUB1_CODE;
        end
        return v ^ ESC_FLIP;
    endfunction

endpackage

// ----- rtl/zdse_cfg.sv -----
module zdse_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [zdse_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [zdse_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [zdse_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output zdse_pkg::cfg_t                     cfg,
    output logic                               mode_wr
);
    import zdse_pkg::*;

    logic     crc32_mode_reg, crc32_mode_next;
    logic     esc_ctl_reg, esc_ctl_next;
    logic     wr_en;
    reg_idx_t idx;

    assign idx     = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign mode_wr = wr_en && (idx == REG_CRC32_MODE);

    always_comb begin
        crc32_mode_next = crc32_mode_reg;
        esc_ctl_next    = esc_ctl_reg;
        if (mode_wr) begin
            crc32_mode_next = pwdata[0];
        end
        if (wr_en && (idx == REG_ESCAPE_CONTROL)) begin
            esc_ctl_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc32_mode_reg <= 1'b0;
            esc_ctl_reg    <= 1'b0;
        end else begin
            crc32_mode_reg <= crc32_mode_next;
            esc_ctl_reg    <= esc_ctl_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_CRC32_MODE:     prdata[0] = crc32_mode_reg;
            REG_ESCAPE_CONTROL: prdata[0] = esc_ctl_reg;
            default:            prdata    = '0;
        endcase
    end

    assign cfg.crc32_mode     = crc32_mode_reg;
    assign cfg.escape_control = esc_ctl_reg;

endmodule

// ----- rtl/zdse_crc.sv -----
module zdse_crc (
    input  logic              aclk,
    input  logic              aresetn,
    input  zdse_pkg::cfg_t    cfg,
    input  logic              mode_wr,
    input  logic              new_mode,
    input  logic              s_accept,
    input  zdse_pkg::in_item_t s_data,
    output logic [31:0]       crc_data,
    output logic [31:0]       crc_cur
);
    import zdse_pkg::*;

    logic [31:0] crc_reg, crc_next;

    // Running CRC with the item's payload byte folded in.
    assign crc_data = s_data.has_byte ? crc_fold(crc_reg, s_data.data_byte, cfg.crc32_mode)
                                      : crc_reg;
    assign crc_cur  = crc_reg;

    always_comb begin
        crc_next = crc_reg;
        if (mode_wr) begin
            crc_next = crc_init(new_mode);
        end else if (s_accept) begin
            crc_next = s_data.last ? crc_init(cfg.crc32_mode) : crc_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC16_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ----- rtl/zdse_seq.sv -----
module zdse_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  zdse_pkg::cfg_t      cfg,
    input  logic                s_valid,
    input  zdse_pkg::in_item_t  s_data,
    input  logic [31:0]         crc_data,
    output logic                s_ready,
    input  logic                m_ready,
    output logic                m_valid,
    output zdse_pkg::out_item_t m_data,
    output zdse_pkg::seq_stat_t stat
);
    import zdse_pkg::*;

    typedef enum logic [2:0] {
        TOK_DATA,
        TOK_ZDLE,
        TOK_FE,
        TOK_CRC0,
        TOK_CRC1,
        TOK_CRC2,
        TOK_CRC3,
        TOK_XON
    } tok_t;

    // Item register
    logic        busy_reg;
    in_item_t    itm_reg;
    logic [31:0] crc_reg;
    tok_t        tok_reg, tok_next;
    logic        phase_reg;

    // Output register
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic        fire, load, tok_done, final_tok, tok_esc, ack_end;
    logic [7:0]  tok_val, fe_byte, line_byte;
    logic [31:0] tcrc;

    assign fe_byte = FRAME_END_BASE + {6'd0, itm_reg.frame_end_code};
    assign ack_end = (itm_reg.frame_end_code == FE_ACK);

    always_comb begin
        tcrc = crc_fold(crc_reg, fe_byte, cfg.crc32_mode);
        if (cfg.crc32_mode) begin
            tcrc = ~tcrc;
        end
    end

    always_comb begin
        tok_val   = ZDLE_CODE;
        tok_esc   = 1'b0;
        tok_next  = TOK_ZDLE;
        final_tok = 1'b0;
        case (tok_reg)
            TOK_DATA: begin
                tok_val   = itm_reg.data_byte;
                tok_esc   = 1'b1;
                tok_next  = TOK_ZDLE;
                final_tok = !itm_reg.last;
            end
            TOK_ZDLE: begin
                tok_val  = ZDLE_CODE;
                tok_next = TOK_FE;
            end
            TOK_FE: begin
                tok_val  = fe_byte;
                tok_next = TOK_CRC0;
            end
            TOK_CRC0: begin
                tok_val  = cfg.crc32_mode ? tcrc[7:0] : tcrc[15:8];
                tok_esc  = 1'b1;
                tok_next = TOK_CRC1;
            end
            TOK_CRC1: begin
                tok_val   = cfg.crc32_mode ? tcrc[15:8] : tcrc[7:0];
                tok_esc   = 1'b1;
                tok_next  = cfg.crc32_mode ? TOK_CRC2 : TOK_XON;
                final_tok = !cfg.crc32_mode && !ack_end;
            end
            TOK_CRC2: begin
                tok_val  = tcrc[23:16];
                tok_esc  = 1'b1;
                tok_next = TOK_CRC3;
            end
            TOK_CRC3: begin
                tok_val   = tcrc[31:24];
                tok_esc   = 1'b1;
                tok_next  = TOK_XON;
                final_tok = !ack_end;
            end
            TOK_XON: begin
                tok_val   = XON_CODE;
                final_tok = 1'b1;
            end
            default: begin
                tok_val = ZDLE_CODE;
            end
        endcase
    end

    // Escaped tokens take two line bytes: ZDLE, then the translated value.
    always_comb begin
        tok_done  = 1'b1;
        line_byte = tok_val;
        if (tok_esc && esc_needed(tok_val, cfg.escape_control)) begin
            tok_done  = phase_reg;
            line_byte = phase_reg ? esc_second(tok_val, cfg.escape_control) : ZDLE_CODE;
        end
    end

    assign fire    = busy_reg && (!m_valid_reg || m_ready);
    assign s_ready = !busy_reg || (fire && tok_done && final_tok);
    // Items with neither a byte nor an end produce nothing and are dropped.
    assign load    = s_valid && s_ready && (s_data.has_byte || s_data.last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            tok_reg     <= TOK_DATA;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                tok_reg   <= s_data.has_byte ? TOK_DATA : TOK_ZDLE;
            end else if (fire) begin
                if (tok_done && final_tok) begin
                    busy_reg <= 1'b0;
                end
                if (tok_done) begin
                    tok_reg   <= tok_next;
                    phase_reg <= 1'b0;
                end else begin
                    phase_reg <= 1'b1;
                end
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load) begin
                itm_reg <= s_data;
                crc_reg <= crc_data;
            end
            if (fire) begin
                m_data_reg.out_byte <= line_byte;
                m_data_reg.out_last <= tok_done && final_tok;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign stat.busy = busy_reg;
    assign stat.fire = fire;

endmodule

// ----- rtl/zmodem_data_subpacket_encoder.sv -----
// Channel   Direction  Payload              Handshake
// s_        in         in_item_t (12 bits)  s_valid / s_ready
// m_        out        out_item_t (9 bits)  m_valid / m_ready
// apb       in/out     2 x 1-bit registers  psel/penable, pready tied high
//
// One line byte leaves per cycle unless m_ready stalls the output; a payload byte makes 1 or 2
// line bytes and an item up to 13 with a CRC-32 trailer and XON, stepped out by the
// single item register through the item's bytes into the output register.
// The next item is taken in the cycle the current one emits its final byte.
// Reset is synchronous, active low; afterwards CRC-16 mode, no control escaping.
// A stall on m_ready holds the output register and the item register in place.
module zmodem_data_subpacket_encoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [zdse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [zdse_pkg::APB_DATA_W-1:0] pwdata,
    output logic [zdse_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  zdse_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output zdse_pkg::out_item_t             m_data
);
    import zdse_pkg::*;

    cfg_t        cfg;
    seq_stat_t   stat;
    logic        mode_wr;
    logic        s_accept;
    logic [31:0] crc_data;
    logic [31:0] crc_cur;

    assign s_accept = s_valid && s_ready;

    zdse_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .mode_wr (mode_wr)
    );

    zdse_crc u_crc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .mode_wr  (mode_wr),
        .new_mode (pwdata[0]),
        .s_accept (s_accept),
        .s_data   (s_data),
        .crc_data (crc_data),
        .crc_cur  (crc_cur)
    );

    zdse_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_data   (s_data),
        .crc_data (crc_data),
        .s_ready  (s_ready),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data),
        .stat     (stat)
    );

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_crc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.last) |=> (crc_cur == crc_init(cfg.crc32_mode)))
        else $error("CRC not re-initialized after subpacket end");

    a_empty_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_data.has_byte && !s_data.last) |=> !stat.busy)
        else $error("empty transaction left the sequencer busy");

    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fire |=> m_valid)
        else $error("emitted byte not presented on the output");

    a_item_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.busy && !stat.fire) |=> stat.busy)
        else $error("item dropped while stalled");

endmodule

// ----- verif/tb_zmodem_data_subpacket_encoder.sv -----
`timescale 1ns / 1ps

module tb_zmodem_data_subpacket_encoder;
    import zdse_pkg::*;

    localparam int DRAIN_SETTLE   = 8;
    localparam int END_SETTLE     = 20;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT    = 2000;
    localparam int BLOCK_ITEMS    = 32;
    localparam int MAX_PRINTED    = 100;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // n_bytes < 0: expected line bytes come from the encoder model
    typedef struct {
        row_kind_t  kind;
        in_item_t   item;
        reg_idx_t   idx;
        logic       val;
        int         n_bytes;
        logic [7:0] b0;
        logic [7:0] b1;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    // encoder model state
    logic        mdl_crc32;
    logic        mdl_esc_ctl;
    logic [31:0] line_crc;
    logic [7:0]  enc_bytes[$];

    out_item_t line_exp_q[$];
    dir_row_t  dir_rows[$];

    int err_count    = 0;
    int stall_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit rx_hold_req  = 1'b0;

    zmodem_data_subpacket_encoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("mismatch @%0t: %s", $time, what);
        end
    endtask

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        int          i;
        c = crc;
        if (mdl_crc32) begin
            // reflected: data enters at bit 0, lsb first
            for (i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = (c >> 1) ^ (fb ? POLY32 : 32'h0);
            end
        end else begin
            for (i = 0; i < 8; i++) begin
                fb = c[15] ^ b[7-i];
                c  = {16'h0, c[14:0], 1'b0} ^ (fb ? {16'h0, POLY16} : 32'h0);
            end
        end
        return c;
    endfunction

    function automatic bit flow_sensitive(input logic [7:0] v);
        case (v)
            ZDLE_CODE, DLE_CODE, DLE_CODE | HIGH_BIT, XON_CODE, XON_CODE | HIGH_BIT,
            XOFF_CODE, XOFF_CODE | HIGH_BIT, CR_CODE, CR_CODE | HIGH_BIT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void put_escaped(input logic [7:0] v);
        if (mdl_esc_ctl && (v == DEL_CODE || v == DEL_HI_CODE)) begin
            enc_bytes.push_back(ZDLE_CODE);
            enc_bytes.push_back((v == DEL_CODE) ? RUB0_CODE : RUB1_CODE);
        end else if (flow_sensitive(v) || (mdl_esc_ctl && (v & CTRL_MASK) == 8'h00)) begin
            enc_bytes.push_back(ZDLE_CODE);
            enc_bytes.push_back(v ^ ESC_FLIP);
        end else begin
            enc_bytes.push_back(v);
        end
    endfunction

    // Line bytes one transaction produces; updates the running CRC.
    function automatic void encode_item(input in_item_t it);
        logic [7:0]  fe;
        logic [31:0] c;
        int          i;
        enc_bytes.delete();
        if (it.has_byte) begin
            line_crc = crc_byte(line_crc, it.data_byte);
            put_escaped(it.data_byte);
        end
        if (it.last) begin
            fe = FRAME_END_BASE + 8'(it.frame_end_code);
            enc_bytes.push_back(ZDLE_CODE);
            enc_bytes.push_back(fe);
            c = crc_byte(line_crc, fe);
            if (mdl_crc32) begin
                c = ~c;
                for (i = 0; i < 4; i++) begin
                    put_escaped(c[8*i +: 8]);
                end
            end else begin
                put_escaped(c[15:8]);
                put_escaped(c[7:0]);
            end
            if (it.frame_end_code == FE_ACK) begin
                enc_bytes.push_back(XON_CODE);
            end
            line_crc = mdl_crc32 ? CRC32_INIT : CRC16_INIT;
        end
    endfunction

    function automatic dir_row_t item_row(input logic [7:0] d, input logic has, input logic lst,
                                          input logic [1:0] fe, input int n,
                                          input logic [7:0] b0, input logic [7:0] b1);
        dir_row_t r;
        r.kind                = ROW_ITEM;
        r.item.data_byte      = d;
        r.item.has_byte       = has;
        r.item.last           = lst;
        r.item.frame_end_code = fe;
        r.idx                 = REG_CRC32_MODE;
        r.val                 = 1'b0;
        r.n_bytes             = n;
        r.b0                  = b0;
        r.b1                  = b1;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input reg_idx_t idx, input logic val);
        dir_row_t r;
        r         = item_row(8'h00, 1'b0, 1'b0, 2'd0, 0, 8'h00, 8'h00);
        r.kind    = ROW_CFG;
        r.idx     = idx;
        r.val     = val;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(2) != 0) begin
            return 8'($urandom_range(255));
        end
        case ($urandom_range(15))
            0:  return ZDLE_CODE;
            1:  return DLE_CODE;
            2:  return DLE_CODE | HIGH_BIT;
            3:  return XON_CODE;
            4:  return XON_CODE | HIGH_BIT;
            5:  return XOFF_CODE;
            6:  return XOFF_CODE | HIGH_BIT;
            7:  return CR_CODE;
            8:  return CR_CODE | HIGH_BIT;
            9:  return DEL_CODE;
            10: return DEL_HI_CODE;
            11: return 8'h00;
            12: return 8'h1f;
            13: return 8'h9f;
            14: return ZDLE_CODE | HIGH_BIT;
            default: return 8'h60;
        endcase
    endfunction

    // Write one register, then read it back.
    task automatic write_reg(input reg_idx_t idx, input logic val);
        logic [APB_DATA_W-1:0] wr_word;
        wr_word    = $urandom();
        wr_word[0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wr_word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_CRC32_MODE) begin
            mdl_crc32 = val;
            line_crc  = val ? CRC32_INIT : CRC16_INIT;
        end else begin
            mdl_esc_ctl = val;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(val)) begin
            report_mismatch($sformatf("reg %0d reads %h, wrote %0d", idx, prdata, val));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stop offering and wait until every expected byte has left the block.
    task automatic drain_line();
        s_valid <= 1'b0;
        while (line_exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    task automatic push_item(input in_item_t it, input int typed_n,
                             input logic [7:0] tb0, input logic [7:0] tb1);
        out_item_t o;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        encode_item(it);
        if (typed_n >= 0) begin
            enc_bytes.delete();
            if (typed_n > 0) enc_bytes.push_back(tb0);
            if (typed_n > 1) enc_bytes.push_back(tb1);
        end
        foreach (enc_bytes[k]) begin
            o.out_byte = enc_bytes[k];
            o.out_last = (k == enc_bytes.size() - 1);
            line_exp_q.push_back(o);
        end
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Random subpackets; empty items are noise and are not counted.
    task automatic run_random(input int n_items, input bit pressure);
        in_item_t it;
        int       sent;
        int       plen;
        int       k;
        bit       counted;
        sent = 0;
        while (sent < n_items) begin
            plen = $urandom_range(9);
            for (k = 0; k <= plen && sent < n_items; k++) begin
                it.data_byte      = pick_byte();
                it.frame_end_code = 2'($urandom_range(3));
                it.last           = (k == plen);
                it.has_byte       = (k < plen) ? 1'b1 : 1'($urandom_range(1));
                if (!it.last && $urandom_range(19) == 0) begin
                    it.has_byte = 1'b0;
                end
                push_item(it, -1, 8'h00, 8'h00);
                counted = it.has_byte || it.last;
                if (counted) sent++;
                if (pressure && counted && sent == 8) begin
                    rx_hold_req = 1'b1;
                end
                if (pressure && counted && sent == 24) begin
                    drain_line();
                end
            end
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : line_check
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (line_exp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %h", m_data.out_byte));
            end else begin
                e = line_exp_q.pop_front();
                if (m_data.out_byte !== e.out_byte) begin
                    report_mismatch($sformatf("out_byte %h, expected %h",
                                              m_data.out_byte, e.out_byte));
                end
                if (m_data.out_last !== e.out_last) begin
                    report_mismatch($sformatf("out_last %b, expected %b (byte %h)",
                                              m_data.out_last, e.out_last, e.out_byte));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("[zmodem_data_subpacket_encoder] ERROR");
            $finish;
        end
    end

    initial begin
        out_item_t e;
        int        p;
        int        blk;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        mdl_crc32   = 1'b0;
        mdl_esc_ctl = 1'b0;
        line_crc    = CRC16_INIT;

        // after reset: CRC-16, no control escaping
        dir_rows.push_back(item_row(8'h41, 1, 0, 0, 1, 8'h41, 8'h00));
        dir_rows.push_back(item_row(8'h18, 1, 0, 0, 2, 8'h18, 8'h58));
        dir_rows.push_back(item_row(8'h10, 1, 0, 1, 2, 8'h18, 8'h50));
        dir_rows.push_back(item_row(8'h90, 1, 0, 2, 2, 8'h18, 8'hd0));
        dir_rows.push_back(item_row(8'h11, 1, 0, 3, 2, 8'h18, 8'h51));
        dir_rows.push_back(item_row(8'h93, 1, 0, 0, 2, 8'h18, 8'hd3));
        dir_rows.push_back(item_row(8'h0d, 1, 0, 0, 2, 8'h18, 8'h4d));
        dir_rows.push_back(item_row(8'h8d, 1, 0, 0, 2, 8'h18, 8'hcd));
        dir_rows.push_back(item_row(8'h00, 1, 0, 0, 1, 8'h00, 8'h00));
        dir_rows.push_back(item_row(8'hff, 1, 0, 0, 1, 8'hff, 8'h00));
        dir_rows.push_back(item_row(8'h5a, 0, 0, 3, 0, 8'h00, 8'h00));
        dir_rows.push_back(item_row(8'h7f, 1, 1, 0, -1, 8'h00, 8'h00));
        // empty subpacket, acknowledge ending
        dir_rows.push_back(item_row(8'hff, 0, 1, 3, -1, 8'h00, 8'h00));
        dir_rows.push_back(cfg_row(REG_ESCAPE_CONTROL, 1'b1));
        dir_rows.push_back(item_row(8'h7f, 1, 0, 0, 2, 8'h18, 8'h6c));
        dir_rows.push_back(item_row(8'hff, 1, 0, 0, 2, 8'h18, 8'h6d));
        dir_rows.push_back(item_row(8'h01, 1, 0, 0, 2, 8'h18, 8'h41));
        dir_rows.push_back(item_row(8'h9f, 1, 0, 0, 2, 8'h18, 8'hdf));
        dir_rows.push_back(item_row(8'h20, 1, 0, 0, 1, 8'h20, 8'h00));
        dir_rows.push_back(item_row(8'h60, 1, 1, 1, -1, 8'h00, 8'h00));
        dir_rows.push_back(cfg_row(REG_CRC32_MODE, 1'b1));
        dir_rows.push_back(item_row(8'h55, 1, 0, 0, 1, 8'h55, 8'h00));
        dir_rows.push_back(item_row(8'ha5, 1, 1, 3, -1, 8'h00, 8'h00));
        dir_rows.push_back(item_row(8'h00, 0, 1, 2, -1, 8'h00, 8'h00));
        dir_rows.push_back(item_row(8'h33, 1, 0, 0, 1, 8'h33, 8'h00));
        // mode write mid-subpacket restarts the CRC
        dir_rows.push_back(cfg_row(REG_CRC32_MODE, 1'b1));
        dir_rows.push_back(item_row(8'hc3, 1, 1, 0, -1, 8'h00, 8'h00));
        dir_rows.push_back(cfg_row(REG_CRC32_MODE, 1'b0));
        dir_rows.push_back(item_row(8'h12, 1, 0, 0, 2, 8'h18, 8'h52));
        dir_rows.push_back(cfg_row(REG_ESCAPE_CONTROL, 1'b0));
        dir_rows.push_back(item_row(8'h80, 1, 1, 3, -1, 8'h00, 8'h00));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_line();
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                push_item(dir_rows[r].item, dir_rows[r].n_bytes, dir_rows[r].b0, dir_rows[r].b1);
            end
        end

        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 26;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (blk = 0; blk < 2; blk++) begin
                drain_line();
                write_reg(REG_CRC32_MODE, 1'($urandom_range(1)));
                write_reg(REG_ESCAPE_CONTROL, 1'($urandom_range(1)));
                run_random(BLOCK_ITEMS, p == 0 && blk == 0);
            end
        end

        s_valid <= 1'b0;
        while (line_exp_q.size() != 0) @(posedge aclk);
        repeat (END_SETTLE) @(posedge aclk);
        while (line_exp_q.size() != 0) begin
            e = line_exp_q.pop_front();
            report_mismatch($sformatf("missing byte %h", e.out_byte));
        end

        if (err_count == 0) begin
            $display("[zmodem_data_subpacket_encoder] OK");
        end else begin
            $display("[zmodem_data_subpacket_encoder] ERROR");
        end
        $finish;
    end

endmodule
